// ===== rtl/core/sdaf_pkg.sv =====
// sdaf_pkg: shared constants, state types and status structs of the signed
// decimal ASCII formatter. Depends on nothing; every other rtl/core file uses it.
package sdaf_pkg;

   localparam int MAX_WIDTH_DEFAULT = 16;
   localparam int VALUE_W           = 32;
   localparam int FWIDTH_W          = 5;
   localparam int CHAR_W            = 8;
   localparam int DIGITS            = 10;
   localparam int BCD_W             = DIGITS * 4;
   localparam int NDIG_W            = 4;
   localparam int BITCNT_W          = $clog2(VALUE_W);

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      BCD_IDLE,
      BCD_SHIFT,
      BCD_NORM
   } bcd_state_type;

   typedef struct packed {
      logic              done;
      logic [NDIG_W-1:0] ndigits;
   } bcd_status_type;

   typedef struct packed {
      logic              busy;
      logic              last_char;
      logic [CHAR_W-1:0] character;
   } emit_status_type;

endpackage

// ===== rtl/core/sdaf_if.sv =====
// sdaf_if: valid/ready channel interfaces for the formatter's request and
// response items. Depends on sdaf_pkg for field widths.
interface sdaf_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sdaf_pkg::VALUE_W-1:0] value;
   logic [sdaf_pkg::FWIDTH_W-1:0]       field_width;
   logic                                zero_fill;

   modport source (output valid, output value, output field_width, output zero_fill,
                   input ready);
   modport sink   (input valid, input value, input field_width, input zero_fill,
                   output ready);
endinterface

interface sdaf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sdaf_pkg::CHAR_W-1:0]  character;
   logic                         last_char;

   modport source (output valid, output character, output last_char, input ready);
   modport sink   (input valid, input character, input last_char, output ready);
endinterface

// ===== rtl/core/sdaf_bcd.sv =====
// sdaf_bcd: bit-serial binary to BCD converter (shift and add-3), followed by
// a digit-serial pass that drops leading zero digits. Depends on sdaf_pkg.
module sdaf_bcd (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sdaf_pkg::VALUE_W-1:0]    magnitude,
   output logic [sdaf_pkg::BCD_W-1:0]      digits,
   output sdaf_pkg::bcd_status_type        status
);

   sdaf_pkg::bcd_state_type          state_ff, state_in;
   logic [sdaf_pkg::BCD_W-1:0]       bcd_ff, bcd_in;
   logic [sdaf_pkg::VALUE_W-1:0]     bin_ff, bin_in;
   logic [sdaf_pkg::BITCNT_W-1:0]    cnt_ff, cnt_in;
   logic [sdaf_pkg::NDIG_W-1:0]      nd_ff, nd_in;
   logic [sdaf_pkg::BCD_W-1:0]       adj;
   logic                             last_bit;
   logic                             can_drop;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < sdaf_pkg::DIGITS; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                     : bcd_ff[i*4 +: 4];
      end
   end

   assign last_bit = (cnt_ff == sdaf_pkg::BITCNT_W'(sdaf_pkg::VALUE_W - 1));
   assign can_drop = (bcd_ff[sdaf_pkg::BCD_W-1 -: 4] == 4'd0) && (nd_ff > 4'd1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdaf_pkg::BCD_IDLE:  if (start) state_in = sdaf_pkg::BCD_SHIFT;
         sdaf_pkg::BCD_SHIFT: if (last_bit) state_in = sdaf_pkg::BCD_NORM;
         sdaf_pkg::BCD_NORM:  if (!can_drop) state_in = sdaf_pkg::BCD_IDLE;
         default:             state_in = sdaf_pkg::BCD_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      bcd_in         = bcd_ff;
      bin_in         = bin_ff;
      cnt_in         = cnt_ff;
      nd_in          = nd_ff;
      status.done    = 1'b0;
      status.ndigits = nd_ff;
      unique case (state_ff)
         sdaf_pkg::BCD_IDLE: begin
            if (start) begin
               bcd_in = '0;
               bin_in = magnitude;
               cnt_in = '0;
               nd_in  = sdaf_pkg::NDIG_W'(sdaf_pkg::DIGITS);
            end
         end
         sdaf_pkg::BCD_SHIFT: begin
            {bcd_in, bin_in} = {adj[sdaf_pkg::BCD_W-2:0], bin_ff, 1'b0};
            cnt_in           = cnt_ff + 1'b1;
         end
         sdaf_pkg::BCD_NORM: begin
            if (can_drop) begin
               bcd_in = {bcd_ff[sdaf_pkg::BCD_W-5:0], 4'd0};
               nd_in  = nd_ff - 1'b1;
            end else begin
               status.done = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdaf_pkg::BCD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
      cnt_ff <= cnt_in;
      nd_ff  <= nd_in;
   end

   assign digits = bcd_ff;

endmodule

// ===== rtl/core/sdaf_emit.sv =====
// sdaf_emit: character sequencer; walks sign, padding and digits left to
// right, one character per step, digits leaving a 40-bit shift register.
// Depends on sdaf_pkg.
module sdaf_emit #(
   parameter int MAX_WIDTH = sdaf_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              step,
   input  logic [sdaf_pkg::BCD_W-1:0]        digits,
   input  logic [sdaf_pkg::NDIG_W-1:0]       ndigits,
   input  logic                              neg,
   input  logic                              zero_fill,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]    width,
   output sdaf_pkg::emit_status_type         status
);

   localparam int WID_W = $clog2(MAX_WIDTH + 1);

   logic                         busy_ff, busy_in;
   logic [WID_W-1:0]             pos_ff, pos_in;
   logic [WID_W-1:0]             total_ff, total_in;
   logic [WID_W-1:0]             pad_ff, pad_in;
   logic [WID_W-1:0]             prefix_ff, prefix_in;
   logic                         neg_ff, neg_in;
   logic                         zf_ff, zf_in;
   logic [sdaf_pkg::BCD_W-1:0]   dig_ff, dig_in;
   logic [WID_W-1:0]             text_len;
   logic [WID_W-1:0]             sign_pos;
   logic                         in_prefix;
   logic                         is_last;
   logic [sdaf_pkg::CHAR_W-1:0]  char_sel;

   assign text_len  = WID_W'(ndigits) + WID_W'(neg);
   assign sign_pos  = zf_ff ? '0 : pad_ff;
   assign in_prefix = (pos_ff < prefix_ff);
   assign is_last   = (pos_ff == total_ff - 1'b1);

   always_comb begin
      if (!in_prefix) begin
         char_sel = sdaf_pkg::ASCII_ZERO + {4'd0, dig_ff[sdaf_pkg::BCD_W-1 -: 4]};
      end else if (neg_ff && (pos_ff == sign_pos)) begin
         char_sel = sdaf_pkg::ASCII_MINUS;
      end else begin
         char_sel = zf_ff ? sdaf_pkg::ASCII_ZERO : sdaf_pkg::ASCII_SPACE;
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      pos_in    = pos_ff;
      total_in  = total_ff;
      pad_in    = pad_ff;
      prefix_in = prefix_ff;
      neg_in    = neg_ff;
      zf_in     = zf_ff;
      dig_in    = dig_ff;
      if (start) begin
         busy_in   = 1'b1;
         pos_in    = '0;
         total_in  = (width > text_len) ? width : text_len;
         pad_in    = total_in - text_len;
         prefix_in = pad_in + WID_W'(neg);
         neg_in    = neg;
         zf_in     = zero_fill;
         dig_in    = digits;
      end else if (step && busy_ff) begin
         pos_in = pos_ff + 1'b1;
         if (!in_prefix) dig_in = {dig_ff[sdaf_pkg::BCD_W-5:0], 4'd0};
         if (is_last) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      pos_ff    <= pos_in;
      total_ff  <= total_in;
      pad_ff    <= pad_in;
      prefix_ff <= prefix_in;
      neg_ff    <= neg_in;
      zf_ff     <= zf_in;
      dig_ff    <= dig_in;
   end

   assign status.busy      = busy_ff;
   assign status.last_char = is_last;
   assign status.character = char_sel;

endmodule

// ===== rtl/core/signed_decimal_ascii_formatter_unit.sv =====
// signed_decimal_ascii_formatter_unit: top level of the formatter; control
// FSM and response register. Depends on sdaf_pkg, sdaf_if, sdaf_bcd, sdaf_emit.
//
//   channel   dir   handshake      payload
//   req_chan  in    valid/ready    value[31:0] signed, field_width[4:0], zero_fill
//   rsp_chan  out   valid/ready    character[7:0], last_char
//
// Steps: one item takes an accept, 32 shift-and-add-3 steps (one bit of
//   the magnitude a cycle), (10 - digits) leading-zero drops, a hand-off,
//   and one character per cycle while rsp_chan.ready is high;
//   characters = max(min(field_width, MAX_WIDTH), digits + sign).
// Reset: synchronous, active high; clears the FSMs and the response valid.
// Stalls: rsp_chan.ready low with a character held in the response register freezes
//   the character sequencer; a new item is taken once the last character sits there.
module signed_decimal_ascii_formatter_unit #(
   parameter int MAX_WIDTH = sdaf_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   sdaf_req_if.sink      req_chan,
   sdaf_rsp_if.source    rsp_chan
);

   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = (WID_W > sdaf_pkg::FWIDTH_W) ? WID_W : sdaf_pkg::FWIDTH_W;

   sdaf_pkg::ctrl_state_type       state_ff, state_in;
   logic                           neg_ff, neg_in;
   logic                           zf_ff, zf_in;
   logic [WID_W-1:0]               width_ff, width_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sdaf_pkg::CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           req_fire;
   logic                           bcd_start;
   logic                           emit_start;
   logic                           emit_step;
   logic                           req_neg;
   logic [sdaf_pkg::VALUE_W-1:0]   req_mag;
   logic [CMP_W-1:0]               fw_ext;
   logic [sdaf_pkg::BCD_W-1:0]     bcd_digits;
   sdaf_pkg::bcd_status_type       bcd_stat;
   sdaf_pkg::emit_status_type      emit_stat;

   assign req_fire = req_chan.valid && req_chan.ready;

   // two's complement magnitude; the most negative value maps to 2^31 as unsigned
   assign req_neg = req_chan.value[sdaf_pkg::VALUE_W-1];
   assign req_mag = req_neg ? (sdaf_pkg::VALUE_W'(0) - $unsigned(req_chan.value))
                            : $unsigned(req_chan.value);
   assign fw_ext  = CMP_W'(req_chan.field_width);

   // capture per-item controls; width saturates at MAX_WIDTH
   always_comb begin
      neg_in   = neg_ff;
      zf_in    = zf_ff;
      width_in = width_ff;
      if (req_fire) begin
         neg_in   = req_neg;
         zf_in    = req_chan.zero_fill;
         width_in = (fw_ext > CMP_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH)
                                                 : WID_W'(req_chan.field_width);
      end
   end

   // FSM next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdaf_pkg::ST_IDLE: if (req_fire) state_in = sdaf_pkg::ST_CONV;
         sdaf_pkg::ST_CONV: if (bcd_stat.done) state_in = sdaf_pkg::ST_EMIT;
         sdaf_pkg::ST_EMIT: if (emit_step && emit_stat.last_char) state_in = sdaf_pkg::ST_IDLE;
         default:           state_in = sdaf_pkg::ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_chan.ready = 1'b0;
      bcd_start      = 1'b0;
      emit_start     = 1'b0;
      emit_step      = 1'b0;
      unique case (state_ff)
         sdaf_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            bcd_start      = req_chan.valid;
         end
         sdaf_pkg::ST_CONV: emit_start = bcd_stat.done;
         sdaf_pkg::ST_EMIT: emit_step  = emit_stat.busy && (!rsp_valid_ff || rsp_chan.ready);
         default: ;
      endcase
   end

   sdaf_bcd u_bcd (
      .clock     (clock),
      .reset     (reset),
      .start     (bcd_start),
      .magnitude (req_mag),
      .digits    (bcd_digits),
      .status    (bcd_stat)
   );

   sdaf_emit #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .start     (emit_start),
      .step      (emit_step),
      .digits    (bcd_digits),
      .ndigits   (bcd_stat.ndigits),
      .neg       (neg_ff),
      .zero_fill (zf_ff),
      .width     (width_ff),
      .status    (emit_stat)
   );

   // response register: decouples the sequencer from the downstream stall
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_step) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_stat.character;
         rsp_last_in  = emit_stat.last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdaf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      zf_ff       <= zf_in;
      width_ff    <= width_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.character = rsp_char_ff;
   assign rsp_chan.last_char = rsp_last_ff;

   // converter finishes only while the FSM waits for it
   a_bcd_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      bcd_stat.done |-> (state_ff == sdaf_pkg::ST_CONV))
      else $error("converter done outside conversion phase");

   // no new item while the sequencer still has characters of the previous one to send
   a_no_accept_while_emit: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !emit_stat.busy)
      else $error("item accepted while sequencer busy");

   // the last character leaves the sequencer idle on the next cycle
   a_last_ends_emit: assert property (@(posedge clock) disable iff (reset)
      (emit_step && emit_stat.last_char) |=> (!emit_stat.busy && rsp_valid_ff && rsp_last_ff))
      else $error("sequencer did not finish on last character");

endmodule
